>>> hw/rtl/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants, register codes and types for the stereo pan gain block.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int PAN_BITS_DEF  = 16;
    localparam int GAIN_BITS_DEF = 16;

    // APB register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_PAN_LAW = 1'b0;
    localparam logic REG_PAN_ALG = 1'b1;

    // pan_law codes
    localparam logic [1:0] LAW_0DB  = 2'd0;
    localparam logic [1:0] LAW_M3DB = 2'd1;
    localparam logic [1:0] LAW_M6DB = 2'd2;

    // pan_algorithm codes
    localparam logic [1:0] ALG_LINEAR = 2'd0;
    localparam logic [1:0] ALG_SQRT   = 2'd1;
    localparam logic [1:0] ALG_SINE   = 2'd2;

    // Q0.32 compensation factors (0.707945784, 0.501187234)
    localparam logic [31:0] COMP_M3DB = 32'd3040603990;
    localparam logic [31:0] COMP_M6DB = 32'd2152582779;

    // Odd Taylor terms of sin(x*pi/2), Q2.30, lowest order first
    localparam int SINE_TERMS = 6;
    localparam logic [31:0] SINE_COEF [SINE_TERMS] = '{
        32'd1686629713, 32'd693598668, 32'd85569306,
        32'd5026995,    32'd172272,    32'd3864
    };

    typedef struct packed {
        logic [1:0] law;
        logic [1:0] alg;
    } cfg_t;

endpackage

>>> hw/rtl/spg_regs.sv
// ----------------------------------------------------------------------------
// spg_regs
// APB register file: pan_law and pan_algorithm.
// ----------------------------------------------------------------------------
module spg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spg_pkg::ADDR_W-1:0] paddr,
    input  logic [spg_pkg::DATA_W-1:0] pwdata,
    output logic [spg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output spg_pkg::cfg_t              cfg
);
    import spg_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.law <= LAW_0DB;
            cfg_reg.alg <= ALG_LINEAR;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_PAN_LAW: cfg_reg.law <= pwdata[1:0];
                REG_PAN_ALG: cfg_reg.alg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_PAN_LAW: prdata[1:0] = cfg_reg.law;
            REG_PAN_ALG: prdata[1:0] = cfg_reg.alg;
            default: prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/spg_sqrt_step.sv
// ----------------------------------------------------------------------------
// spg_sqrt_step
// One digit of a restoring integer square root (two radicand bits per step).
// ----------------------------------------------------------------------------
module spg_sqrt_step #(
    parameter int GAIN_BITS = spg_pkg::GAIN_BITS_DEF
) (
    input  logic [GAIN_BITS+1:0] rem_in,
    input  logic [GAIN_BITS-1:0] root_in,
    input  logic [1:0]           pair,
    output logic [GAIN_BITS+1:0] rem_out,
    output logic [GAIN_BITS-1:0] root_out
);
    localparam int RW = GAIN_BITS + 4;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    assign rem_sh = {rem_in, pair};
    assign trial  = {2'b00, root_in, 2'b01};

    always_comb begin
        if (rem_sh >= trial) begin
            rem_out  = GAIN_BITS'(0) + (GAIN_BITS+2)'(rem_sh - trial);
            root_out = {root_in[GAIN_BITS-2:0], 1'b1};
        end else begin
            rem_out  = (GAIN_BITS+2)'(rem_sh);
            root_out = {root_in[GAIN_BITS-2:0], 1'b0};
        end
    end

endmodule

>>> hw/rtl/spg_horner_step.sv
// ----------------------------------------------------------------------------
// spg_horner_step
// One Horner step of the sine polynomial: coef - floor(s * x2 / 2^32).
// ----------------------------------------------------------------------------
module spg_horner_step (
    input  logic [31:0] s_in,
    input  logic [31:0] x2,
    input  logic [31:0] coef,
    output logic [31:0] s_out
);
    logic [63:0] prod;

    assign prod  = 64'(s_in) * 64'(x2);
    assign s_out = coef - prod[63:32];

endmodule

>>> hw/rtl/spg_comp.sv
// ----------------------------------------------------------------------------
// spg_comp
// Rounds the compensated Q.32 product back to Q0.GAIN_BITS and saturates.
// ----------------------------------------------------------------------------
module spg_comp #(
    parameter int GAIN_BITS = spg_pkg::GAIN_BITS_DEF
) (
    input  logic [GAIN_BITS+32:0] prod,
    output logic [GAIN_BITS-1:0]  gain
);
    localparam int PW = GAIN_BITS + 33;

    logic [PW:0]          sum;
    logic [GAIN_BITS+1:0] rnd;

    assign sum = {1'b0, prod} + (PW+1)'(64'd1 << 31);
    assign rnd = sum[PW:32];

    always_comb begin
        if (|rnd[GAIN_BITS+1:GAIN_BITS]) begin
            gain = '1;
        end else begin
            gain = rnd[GAIN_BITS-1:0];
        end
    end

endmodule

>>> hw/rtl/stereo_pan_gain.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain
// Mono-to-stereo pan gains: linear, square-root or sine law, with optional -3 dB /
// -6 dB pan-law compensation. Fully pipelined, one transfer per clock unless stalled.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Direction  Contents
//  s_        s_valid/s_ready                in         s_pan_position, Q0.PAN_BITS
//  m_        m_valid/m_ready                out        m_gain_l, m_gain_r
//  APB       psel/penable/pwrite/paddr/...  in         pan_law @0x0, pan_algorithm @0x4
//
//  GAIN_BITS + 3 register stages; the last one drives m_. One transfer per cycle is
//  sustained while m_ready is not held low.
//  The depth is set by the square-root unit, one result bit per stage.
//  aresetn (synchronous) clears all stage valid bits and both registers.
//  Each stage holds while its successor is full and stalled; empty stages
//  keep filling, so a stall on m_ready loses and repeats nothing.
//
module stereo_pan_gain #(
    parameter int PAN_BITS  = spg_pkg::PAN_BITS_DEF,
    parameter int GAIN_BITS = spg_pkg::GAIN_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spg_pkg::ADDR_W-1:0] paddr,
    input  logic [spg_pkg::DATA_W-1:0] pwdata,
    output logic [spg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [PAN_BITS-1:0]        s_pan_position,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [GAIN_BITS-1:0]       m_gain_l,
    output logic [GAIN_BITS-1:0]       m_gain_r
);
    import spg_pkg::*;

    // Stage map: 0 clamp, 1..NC sqrt digits (sine polynomial in 1..7),
    // NC+1 curve select and compensation multiply, NC+2 round/saturate.
    localparam int NC = GAIN_BITS;
    localparam int ST = NC + 3;
    localparam int GW = GAIN_BITS + 1;
    localparam int PW = GW + 32;
    localparam int W  = 2 * GAIN_BITS;

    // sqrt radicand alignment: v * 2^(2G-P)
    localparam int E  = 2 * GAIN_BITS - PAN_BITS;
    localparam int EL = (E >= 0) ? E : 0;
    localparam int ER = (E < 0) ? -E : 0;

    // linear rescale Q0.P -> Q0.G
    localparam int SL = (GAIN_BITS >= PAN_BITS) ? GAIN_BITS - PAN_BITS : 0;
    localparam int SR = (PAN_BITS > GAIN_BITS) ? PAN_BITS - GAIN_BITS : 0;
    localparam int LW = PAN_BITS + GAIN_BITS + 1;
    localparam logic [LW-1:0] HALF = (SR > 0) ? (LW'(1) << (SR - 1)) : '0;

    localparam int XS = 32 - PAN_BITS;
    localparam int TW = 33 + GAIN_BITS;

    cfg_t cfg;

    logic [ST-1:0] valid_reg;
    logic [ST-1:0] ready;

    // ch 0 = left (operand 1-p), ch 1 = right (operand p)
    logic [PAN_BITS-1:0]  op_reg   [0:NC][0:1];
    logic [GAIN_BITS+1:0] rem_reg  [1:NC][0:1];
    logic [GAIN_BITS-1:0] root_reg [1:NC][0:1];
    logic [31:0]          x2_reg   [1:NC][0:1];
    logic [31:0]          s_reg    [1:NC][0:1];
    logic [PW-1:0]        prod_reg [0:1];
    logic [GAIN_BITS-1:0] left_reg;
    logic [GAIN_BITS-1:0] right_reg;

    logic [PAN_BITS-1:0] p_clamp;
    logic [GAIN_BITS-1:0] gain_sat [0:1];

    function automatic logic [W-1:0] sqrt_operand(input logic [PAN_BITS-1:0] v);
        return W'(v >> ER) << EL;
    endfunction

    function automatic logic [GW-1:0] lin_gain(input logic [PAN_BITS-1:0] v);
        return GW'(((LW'(v) + HALF) >> SR) << SL);
    endfunction

    spg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- flow control ----------------
    // A stage loads when it is empty or its content moves on this cycle.
    for (genvar k = 0; k < ST - 1; k++) begin : g_ready
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end
    assign ready[ST-1] = !valid_reg[ST-1] || m_ready;

    assign s_ready = ready[0];
    assign m_valid = valid_reg[ST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < ST; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: clamp to 1 .. 2^P-2 ----------------
    always_comb begin
        p_clamp = s_pan_position;
        if (s_pan_position == '0) begin
            p_clamp = PAN_BITS'(1);
        end else if (s_pan_position == '1) begin
            p_clamp = {{(PAN_BITS-1){1'b1}}, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            op_reg[0][0] <= PAN_BITS'(0) - p_clamp;   // 2^P - p
            op_reg[0][1] <= p_clamp;
        end
    end

    // ---------------- stages 1..NC: sqrt digits and sine polynomial --------
    for (genvar k = 1; k <= NC; k++) begin : g_core
        for (genvar c = 0; c < 2; c++) begin : g_ch
            logic [W-1:0]         w;
            logic [GAIN_BITS+1:0] rem_in;
            logic [GAIN_BITS-1:0] root_in;
            logic [GAIN_BITS+1:0] rem_out;
            logic [GAIN_BITS-1:0] root_out;
            logic [31:0]          x;
            logic [31:0]          x2_next;
            logic [31:0]          s_next;

            assign w = sqrt_operand(op_reg[k-1][c]);
            assign x = {op_reg[k-1][c], XS'(0)};

            if (k == 1) begin : g_first
                logic [63:0] xx;
                assign rem_in  = '0;
                assign root_in = '0;
                assign xx      = 64'(x) * 64'(x);
                assign x2_next = xx[63:32];
                assign s_next  = SINE_COEF[SINE_TERMS-1];
            end else begin : g_next
                assign rem_in  = rem_reg[k-1][c];
                assign root_in = root_reg[k-1][c];
                assign x2_next = x2_reg[k-1][c];
                if (k < SINE_TERMS + 1) begin : g_horner
                    spg_horner_step u_horner (
                        .s_in  (s_reg[k-1][c]),
                        .x2    (x2_reg[k-1][c]),
                        .coef  (SINE_COEF[SINE_TERMS-k]),
                        .s_out (s_next)
                    );
                end else if (k == SINE_TERMS + 1) begin : g_sfin
                    // r = s*x (Q2.30), then round to Q0.G
                    logic [63:0]   sx;
                    logic [TW-1:0] t;
                    assign sx     = 64'(s_reg[k-1][c]) * 64'(x);
                    assign t      = {1'b0, sx[63:32], GAIN_BITS'(0)} + TW'(64'd1 << 29);
                    assign s_next = 32'(t[30 +: GW]);
                end else begin : g_hold
                    assign s_next = s_reg[k-1][c];
                end
            end

            spg_sqrt_step #(
                .GAIN_BITS (GAIN_BITS)
            ) u_sqrt (
                .rem_in   (rem_in),
                .root_in  (root_in),
                .pair     (w[2*(NC-k) +: 2]),
                .rem_out  (rem_out),
                .root_out (root_out)
            );

            always_ff @(posedge aclk) begin
                if (ready[k]) begin
                    op_reg[k][c]   <= op_reg[k-1][c];
                    rem_reg[k][c]  <= rem_out;
                    root_reg[k][c] <= root_out;
                    x2_reg[k][c]   <= x2_next;
                    s_reg[k][c]    <= s_next;
                end
            end
        end
    end

    // ---------------- stage NC+1: curve select, compensation multiply ------
    for (genvar c = 0; c < 2; c++) begin : g_comp
        logic [GW-1:0] g;
        logic [PW-1:0] prod_next;

        always_comb begin
            unique case (cfg.alg)
                ALG_LINEAR: g = lin_gain(op_reg[NC][c]);
                ALG_SQRT:   g = GW'(root_reg[NC][c]);
                ALG_SINE:   g = s_reg[NC][c][GW-1:0];
                default:    g = '0;
            endcase
            unique case (cfg.law)
                LAW_M3DB: prod_next = PW'(g) * PW'(COMP_M3DB);
                LAW_M6DB: prod_next = PW'(g) * PW'(COMP_M6DB);
                default:  prod_next = {g, 32'd0};   // 0 dB and unused code
            endcase
        end

        always_ff @(posedge aclk) begin
            if (ready[NC+1]) begin
                prod_reg[c] <= prod_next;
            end
        end

        spg_comp #(
            .GAIN_BITS (GAIN_BITS)
        ) u_comp (
            .prod (prod_reg[c]),
            .gain (gain_sat[c])
        );
    end

    // ---------------- stage NC+2: output register ----------------
    always_ff @(posedge aclk) begin
        if (ready[ST-1]) begin
            left_reg  <= gain_sat[0];
            right_reg <= gain_sat[1];
        end
    end

    assign m_gain_l = left_reg;
    assign m_gain_r = right_reg;

endmodule

>>> tb/stereo_pan_gain_checker.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain_checker
// Watches both streams, predicts the pan gains and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_pan_gain_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_pan_position,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_gain_l,
    input  logic [15:0] m_gain_r,
    output int          fail_count,
    output int          pending
);
    import spg_pkg::*;

    logic [1:0] law_q, alg_q;
    logic [31:0] gain_fifo[$];

    assign pending = gain_fifo.size();

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // sin(x*pi/2) by Horner over x^2, Q2.30 terms
    function automatic logic [63:0] sine16(logic [63:0] v);
        logic [63:0] x, x2, s;
        logic [63:0] cf [6];
        cf = '{64'd1686629713, 64'd693598668, 64'd85569306,
               64'd5026995, 64'd172272, 64'd3864};
        x  = v << 16;
        x2 = (x * x) >> 32;
        s  = cf[5];
        for (int k = 4; k >= 0; k--) s = cf[k] - ((s * x2) >> 32);
        s = (s * x) >> 32;
        return ((s << 16) + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [15:0] compensate(logic [63:0] g, logic [1:0] law);
        if (law == LAW_M3DB) g = (g * 64'd3040603990 + (64'd1 << 31)) >> 32;
        else if (law == LAW_M6DB) g = (g * 64'd2152582779 + (64'd1 << 31)) >> 32;
        return (g > 64'hFFFF) ? 16'hFFFF : g[15:0];
    endfunction

    function automatic logic [31:0] pan_gains(logic [15:0] pos);
        logic [63:0] p, q, l, r;
        p = pos;
        if (p < 1) p = 1;
        if (p > 65534) p = 65534;
        q = 65536 - p;
        case (alg_q)
            ALG_LINEAR: begin l = q; r = p; end
            ALG_SQRT:   begin l = root64(q << 16); r = root64(p << 16); end
            ALG_SINE:   begin l = sine16(q); r = sine16(p); end
            default:    begin l = 0; r = 0; end
        endcase
        return {compensate(l, law_q), compensate(r, law_q)};
    endfunction

    always @(posedge aclk) begin
        logic [31:0] want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            law_q <= LAW_0DB;
            alg_q <= ALG_LINEAR;
            fail_count <= 0;
            gain_fifo.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'd0) law_q <= pwdata[1:0];
                else if (paddr == 3'd4) alg_q <= pwdata[1:0];
            end
            if (s_valid && s_ready) gain_fifo.push_back(pan_gains(s_pan_position));
            if (m_valid && m_ready) begin
                if (gain_fifo.size() == 0) begin
                    $error("unexpected transfer: gain_l %0d gain_r %0d",
                           m_gain_l, m_gain_r);
                    errs++;
                end else begin
                    want = gain_fifo.pop_front();
                    if (want[31:16] !== m_gain_l) begin
                        $error("gain_l expected %0d actual %0d", want[31:16], m_gain_l);
                        errs++;
                    end
                    if (want[15:0] !== m_gain_r) begin
                        $error("gain_r expected %0d actual %0d", want[15:0], m_gain_r);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

>>> tb/stereo_pan_gain_tb.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain_tb
// Stimulus and verdict: walks every pan law and curve, including the unused
// codes, with directed end points and random pans under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_pan_gain_tb;
    import spg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready;
    logic [15:0] s_pan_position = '0;
    logic        m_valid, m_ready = 1'b0;
    logic [15:0] m_gain_l, m_gain_r;
    int          fail_count, pending;
    bit          sink_on = 1'b0;
    int          stall_left = 0;

    always #5 aclk = ~aclk;

    stereo_pan_gain u_dut (.*);

    stereo_pan_gain_checker u_chk (.*);

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure, independent of the source
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_on && $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_left <= gap_len();
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // one pan transfer; holds valid until the DUT takes it
    task automatic send_pan(input logic [15:0] pos, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pan_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);     // pipeline depth margin
    endtask

    initial begin
        logic [15:0] pos;
        bit burst;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sink_on <= 1'b1;

        // directed: end points, clamp edges, mid and alternating bits, all codes
        for (int law = 0; law < 4; law++) begin
            for (int alg = 0; alg < 4; alg++) begin
                reg_write(3'd0, law);
                reg_write(3'd4, alg);
                send_pan(16'h0000, 0); send_pan(16'h0001, 1); send_pan(16'h0002, 0);
                send_pan(16'h8000, 1); send_pan(16'hFFFD, 0); send_pan(16'hFFFE, 1);
                send_pan(16'hFFFF, 0); send_pan(16'h5555, 1); send_pan(16'hAAAA, 0);
                drain();
            end
        end

        // random phases, extremes included via full code sweep above
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(3'd0, (ph < 4) ? ph : $urandom_range(0, 3));
            reg_write(3'd4, (ph < 4) ? 3 - ph : $urandom_range(0, 3));
            for (int n = 0; n < 50; n++) begin
                burst = ($urandom_range(0, 4) == 0);
                pos = 16'($urandom());
                if ($urandom_range(0, 9) == 0) pos = 16'($urandom_range(0, 3));
                else if ($urandom_range(0, 9) == 0) pos = 16'(32'hFFFF - $urandom_range(0, 3));
                send_pan(pos, burst);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/spg_pkg.sv
hw/rtl/spg_regs.sv
hw/rtl/spg_sqrt_step.sv
hw/rtl/spg_horner_step.sv
hw/rtl/spg_comp.sv
hw/rtl/stereo_pan_gain.sv
tb/stereo_pan_gain_checker.sv
tb/stereo_pan_gain_tb.sv
